@@ sv/epsm_pkg.sv @@
// Package for the encoder period speed meter.
// Payload structs, register indexes, item codes and size constants.
// No dependencies.
`default_nettype none

package epsm_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int PERIOD_W_DEF   = TIMER_BITS_DEF + 9;
	localparam int NUM_W          = 32;
	localparam int SPEED_W        = 15;
	localparam int OVF_W          = 8;
	localparam int CAP_W          = 16;
	localparam int FUNC_W         = 2;
	localparam int CFG_IDX_W      = 1;

	localparam logic [SPEED_W-1:0] SPEED_CAP = 15'h7fff;

	localparam logic [FUNC_W-1:0] FUNC_OVF     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CAP     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_OVF_CAP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_OVF   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 1'd1;

	localparam logic [OVF_W-1:0] MAX_OVF_RST   = 8'd4;
	localparam logic [NUM_W-1:0] SPEED_NUM_RST = 32'd1000000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CAP_W-1:0]  capture_value;
	} epsm_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               speed_updated;
	} epsm_result_t;

endpackage

`default_nettype wire

@@ sv/encoder_period_speed_meter.sv @@
// Top level of the encoder period speed meter: item control, period and output register.
// Depends on epsm_pkg and epsm_div.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  item     | item_valid / item_stall   | item   (func, capture_value)
//  result   | result_valid/result_stall | result (speed, speed_updated)
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Overflow-only and first-capture items go through pend_q to the output register.
// A second capture goes through the period sum, then 32 bit-serial divide steps.
// item_stall is high while an item is in flight; the output register holds one
// finished result, so a new item is taken while result_stall is high.
// No clearing pass after reset; cfg writes are always ready.
`default_nettype none

module encoder_period_speed_meter import epsm_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire epsm_item_t           item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output epsm_result_t              result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [NUM_W-1:0]     cfg_data
);

	localparam int PERIOD_W = TIMER_BITS + 9;
	localparam int CW = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
	localparam int BW = TIMER_BITS + 1;
	localparam logic [BW-1:0] TMAX_EXT = {1'b0, {TIMER_BITS{1'b1}}};

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PER  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_POST = 2'd3;

	logic [1:0]          state_q;
	logic [OVF_W-1:0]    max_ovf_q;
	logic [NUM_W-1:0]    num_q;
	logic [CW-1:0]       first_q;
	logic                have_q;
	logic [OVF_W-1:0]    ovf_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [BW-1:0]       base_s1;
	logic [PERIOD_W-1:0] extra_s1;
	epsm_result_t        pend_q;
	epsm_result_t        out_q;
	logic                out_valid_q;

	logic                accept;
	logic                is_ovf;
	logic                is_cap;
	logic [CW-1:0]       cap;
	logic [CW-1:0]       first_n;
	logic                have_n;
	logic [OVF_W-1:0]    ovf_n;
	logic [SPEED_W-1:0]  speed_n;
	logic                upd_n;
	logic                go_div;
	logic [OVF_W-1:0]    k;
	logic [BW-1:0]       base_n;
	logic [PERIOD_W-1:0] extra_n;
	logic [PERIOD_W-1:0] period;
	logic                out_free;
	logic                div_done;
	logic [SPEED_W-1:0]  div_quot;

	assign accept   = item_valid && !item_stall;
	assign cap      = item.capture_value[CW-1:0];
	assign is_ovf   = (item.func == FUNC_OVF) || (item.func == FUNC_OVF_CAP);
	assign is_cap   = (item.func == FUNC_CAP) || (item.func == FUNC_OVF_CAP);
	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		have_n  = have_q;
		first_n = first_q;
		ovf_n   = ovf_q;
		speed_n = speed_q;
		upd_n   = 1'b0;
		go_div  = 1'b0;
		if (is_ovf) begin
			if (({1'b0, ovf_q} + 9'd1) > {1'b0, max_ovf_q}) begin
				have_n  = 1'b0;
				first_n = '0;
				ovf_n   = '0;
				speed_n = '0;
				upd_n   = 1'b1;
			end else begin
				ovf_n = ovf_q + 1'b1;
			end
		end
		if (is_cap) begin
			if (!have_n) begin
				first_n = cap;
				have_n  = 1'b1;
				ovf_n   = '0;
			end else begin
				have_n = 1'b0;
				upd_n  = 1'b1;
				go_div = 1'b1;
			end
		end
	end

	// period pieces: wrap-aware difference, plus TMAX per extra overflow
	assign k       = (ovf_n > 8'd1) ? ovf_n - 1'b1 : '0;
	assign extra_n = {1'b0, k, {TIMER_BITS{1'b0}}} - PERIOD_W'(k);
	assign base_n  = (cap > first_n) ? BW'(cap) - BW'(first_n)
	                                 : TMAX_EXT - BW'(first_n) + BW'(cap);
	assign period  = PERIOD_W'(base_s1) + extra_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_ovf_q   <= MAX_OVF_RST;
			num_q       <= SPEED_NUM_RST;
			first_q     <= '0;
			have_q      <= 1'b0;
			ovf_q       <= '0;
			speed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MAX_OVF:   max_ovf_q <= cfg_data[OVF_W-1:0];
					REG_SPEED_NUM: num_q     <= cfg_data;
				endcase
			end
			if (state_q == ST_POST && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						have_q  <= have_n;
						first_q <= first_n;
						ovf_q   <= ovf_n;
						speed_q <= speed_n;
						state_q <= go_div ? ST_PER : ST_POST;
					end
				end
				ST_PER: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q <= div_quot;
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1  <= base_n;
			extra_s1 <= extra_n;
			pend_q   <= '{speed: speed_n, speed_updated: upd_n};
		end
		if (state_q == ST_DIV && div_done) begin
			pend_q <= '{speed: div_quot, speed_updated: 1'b1};
		end
		if (state_q == ST_POST && out_free) begin
			out_q <= pend_q;
		end
	end

	epsm_div #(
		.DIV_W(PERIOD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_PER),
		.dividend(num_q),
		.divisor (period),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

@@ sv/epsm_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on epsm_pkg.
`default_nettype none

module epsm_div import epsm_pkg::*; #(
	parameter int DIV_W = PERIOD_W_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUM_W-1:0]   dividend,
	input  wire logic [DIV_W-1:0]   divisor,
	output logic                    done,
	output logic [SPEED_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [DIV_W-1:0]   divisor_q;
	logic [DIV_W-1:0]   rem_q;
	logic [SPEED_W-1:0] q_q;
	logic               sat_q;

	logic [DIV_W:0] shifted;
	logic [DIV_W:0] diff;
	logic           ge;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign ge      = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// zero divisor yields all-ones quotient, which saturates to the cap
	always_ff @(posedge clk) begin
		if (start) begin
			num_q     <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
			q_q       <= '0;
			sat_q     <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			q_q   <= {q_q[SPEED_W-2:0], ge};
			sat_q <= sat_q | q_q[SPEED_W-1];
		end
	end

	assign done = done_q;
	assign quot = sat_q ? SPEED_CAP : q_q;

endmodule

`default_nettype wire
